FILE: rtl/bsf_pkg.sv
// Package of the byte stream substring finder: widths, codes, result and cell control types.
// Depends on nothing; every other file of the block imports it.
package bsf_pkg;

  localparam int unsigned MAX_NEEDLE_DEF  = 32;
  localparam int unsigned OFFSET_BITS_DEF = 48;

  localparam int unsigned NEEDLE_BYTES = 32;
  localparam int unsigned NEEDLE_BITS  = NEEDLE_BYTES * 8;
  localparam int unsigned WORD_W       = 64;
  localparam int unsigned START_W      = 48;
  localparam int unsigned NLEN_W       = 6;
  localparam int unsigned LEN_W        = NLEN_W + 1;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned OFS_OUT_W    = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_OFFSET = 3'd0,
    CFG_NEEDLE_LEN   = 3'd1,
    CFG_NEEDLE_W0    = 3'd2,
    CFG_NEEDLE_W1    = 3'd3,
    CFG_NEEDLE_W2    = 3'd4,
    CFG_NEEDLE_W3    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_CANCELLED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_SCAN   = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [OFS_OUT_W-1:0] match_offset;
    status_e              status;
  } result_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

FILE: rtl/byte_stream_substring_finder.sv
// Top level of the byte stream substring finder: config registers, cell chain, evaluation stage.
// Depends on bsf_pkg, bsf_cell and bsf_out_buf.
//
// Takes one file byte per cycle and reports the first exact occurrence of the needle as an offset
// counted from start_offset, or not-found on the last byte of the file or for an empty needle, or
// cancelled. A byte shifts into a chain of MAX_NEEDLE cells on acceptance; in the next cycle
// every cell compares its byte with its needle byte in parallel, and the result is written into a
// two-entry output buffer that feeds the master side. Sustained rate is one byte per cycle, set by
// the shift and parallel compare of the cell chain; the input stalls only while both buffer
// entries wait and the evaluation stage is occupied. Bytes after a result are dropped until a
// byte with the scan-start flag. Write configuration only while idle.
module byte_stream_substring_finder
  import bsf_pkg::*;
#(
  parameter int unsigned MAX_NEEDLE  = MAX_NEEDLE_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // byte_value
  input  logic [1:0]           s_axis_tuser,  // first_of_scan, cancel
  input  logic                 s_axis_tlast,  // last_of_file
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OFS_OUT_W-1:0] m_axis_tdata,  // match_offset
  output logic [1:0]           m_axis_tuser   // status
);

  logic [START_W-1:0]     start_offset_q;
  logic [NLEN_W-1:0]      needle_len_q;
  logic [NEEDLE_BITS-1:0] needle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_offset_q <= '0;
      needle_len_q   <= NLEN_W'(1);
      needle_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_START_OFFSET: start_offset_q <= cfg_wdata_i[START_W-1:0];
        CFG_NEEDLE_LEN:   needle_len_q   <= cfg_wdata_i[NLEN_W-1:0];
        CFG_NEEDLE_W0:    needle_q[0*WORD_W +: WORD_W] <= cfg_wdata_i;
        CFG_NEEDLE_W1:    needle_q[1*WORD_W +: WORD_W] <= cfg_wdata_i;
        CFG_NEEDLE_W2:    needle_q[2*WORD_W +: WORD_W] <= cfg_wdata_i;
        CFG_NEEDLE_W3:    needle_q[3*WORD_W +: WORD_W] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [LEN_W-1:0] len_eff;
  logic             len_zero;

  assign len_eff  = ({1'b0, needle_len_q} > LEN_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE)
                                                                 : {1'b0, needle_len_q};
  assign len_zero = (needle_len_q == '0);

  logic [OFFSET_BITS-1:0] pos_base;
  logic [OFFSET_BITS-1:0] ofs_diff;
  logic [OFS_OUT_W-1:0]   ofs_out;

  generate
    if (OFFSET_BITS >= START_W) begin : g_wide
      assign pos_base = OFFSET_BITS'(start_offset_q);
      assign ofs_out  = ofs_diff[OFS_OUT_W-1:0];
    end else begin : g_narrow
      assign pos_base = start_offset_q[OFFSET_BITS-1:0];
      assign ofs_out  = OFS_OUT_W'(ofs_diff);
    end
  endgenerate

  // input side
  logic first, cancel, last, accept, proceed, fin_eff;
  logic finished_q, finished_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_cur;
  cell_ctrl_t ctrl;

  // evaluation stage
  logic                   s1_v_q;
  kind_e                  s1_kind_q, kind_d;
  logic                   s1_last_q;
  logic [OFFSET_BITS-1:0] s1_pos_q;
  logic                   match, s1_res, s1_adv, buf_full;
  result_t                res;

  assign first   = s_axis_tuser[0];
  assign cancel  = s_axis_tuser[1];
  assign last    = s_axis_tlast;

  assign s_axis_tready = ~s1_v_q | ~buf_full;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign s1_adv        = s1_v_q & ~buf_full;
  assign fin_eff       = finished_q | (s1_v_q & s1_res);
  assign proceed       = accept & (first | ~fin_eff);
  assign ctrl.shift    = proceed & ~cancel & ~len_zero;
  assign ctrl.clear    = accept & first;
  assign pos_cur       = first ? pos_base : pos_q;

  always_comb begin
    if (cancel) begin
      kind_d = KIND_CANCEL;
    end else if (len_zero) begin
      kind_d = KIND_EMPTY;
    end else begin
      kind_d = KIND_SCAN;
    end
  end

  always_comb begin
    finished_d = finished_q | (s1_adv & s1_res);
    if (accept & first) begin
      finished_d = 1'b0;
    end
    if (proceed & (cancel | len_zero)) begin
      finished_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      finished_q <= 1'b1;
      pos_q      <= '0;
      s1_v_q     <= 1'b0;
    end else begin
      finished_q <= finished_d;
      if (proceed) begin
        pos_q <= pos_cur + OFFSET_BITS'(ctrl.shift);
      end
      if (s_axis_tready) begin
        s1_v_q <= proceed;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proceed) begin
      s1_kind_q <= kind_d;
      s1_last_q <= last;
      s1_pos_q  <= pos_cur;
    end
  end

  // cell chain
  logic [7:0]            cell_byte  [MAX_NEEDLE];
  logic [MAX_NEEDLE-1:0] cell_valid;
  logic [MAX_NEEDLE-1:0] cell_hit;

  for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_cell
    logic [LEN_W-1:0] nidx;
    logic             active;
    logic [7:0]       nbyte;
    cell_ctrl_t       cctrl;

    assign active = LEN_W'(k) < len_eff;
    assign nidx   = len_eff - LEN_W'(k) - LEN_W'(1);
    assign nbyte  = (active && nidx < LEN_W'(NEEDLE_BYTES))
                  ? needle_q[{nidx[4:0], 3'b000} +: 8] : 8'd0;

    if (k == 0) begin : g_head
      assign cctrl.shift = ctrl.shift;
      assign cctrl.clear = ctrl.clear & ~ctrl.shift;
      bsf_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (cctrl),
        .byte_i       (s_axis_tdata),
        .valid_i      (1'b1),
        .needle_byte_i(nbyte),
        .active_i     (active),
        .byte_o       (cell_byte[k]),
        .valid_o      (cell_valid[k]),
        .hit_o        (cell_hit[k])
      );
    end else begin : g_body
      assign cctrl = ctrl;
      bsf_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (cctrl),
        .byte_i       (cell_byte[k-1]),
        .valid_i      (cell_valid[k-1]),
        .needle_byte_i(nbyte),
        .active_i     (active),
        .byte_o       (cell_byte[k]),
        .valid_o      (cell_valid[k]),
        .hit_o        (cell_hit[k])
      );
    end
  end

  assign match    = &cell_hit;
  assign ofs_diff = s1_pos_q - OFFSET_BITS'(len_eff - LEN_W'(1));

  always_comb begin
    res.match_offset = '0;
    res.status       = ST_NOT_FOUND;
    s1_res           = 1'b1;
    case (s1_kind_q)
      KIND_CANCEL: res.status = ST_CANCELLED;
      KIND_EMPTY:  res.status = ST_NOT_FOUND;
      KIND_SCAN: begin
        s1_res = match | s1_last_q;
        if (match) begin
          res.status       = ST_FOUND;
          res.match_offset = ofs_out;
        end
      end
      default: ;
    endcase
  end

  result_t out_data;

  bsf_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (s1_adv & s1_res),
    .wr_data_i(res),
    .full_o   (buf_full),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .data_o   (out_data)
  );

  assign m_axis_tdata = out_data.match_offset;
  assign m_axis_tuser = out_data.status;

endmodule

FILE: rtl/bsf_cell.sv
// One history cell: holds one recent byte and its valid flag, compares it with its needle byte.
// Depends on bsf_pkg.
module bsf_cell
  import bsf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic [7:0] byte_i,
  input  logic       valid_i,
  input  logic [7:0] needle_byte_i,
  input  logic       active_i,
  output logic [7:0] byte_o,
  output logic       valid_o,
  output logic       hit_o
);

  logic [7:0] byte_q;
  logic       valid_q, valid_d;

  always_comb begin
    if (ctrl_i.shift) begin
      valid_d = valid_i & ~ctrl_i.clear;
    end else begin
      valid_d = valid_q & ~ctrl_i.clear;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;
  assign hit_o   = ~active_i | (valid_q & (byte_q == needle_byte_i));

endmodule

FILE: rtl/bsf_out_buf.sv
// Two-entry result buffer between the evaluation stage and the output stream.
// Depends on bsf_pkg.
module bsf_out_buf
  import bsf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  result_t wr_data_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  localparam int unsigned DEPTH = 2;

  result_t     slot_q [DEPTH];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;
  logic        pop;

  assign pop     = valid_o & ready_i;
  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'(DEPTH));
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q + 2'(wr_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (wr_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: rtl/bsf_checker.sv
// Port-level checks of the byte stream substring finder, bound to the top level.
// Depends on bsf_pkg and byte_stream_substring_finder.
module bsf_checker
  import bsf_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OFS_OUT_W-1:0] m_axis_tdata,
  input logic [1:0]           m_axis_tuser
);

  default disable iff (!rst_ni);

  a_out_hold: assert property (@(posedge clk_i)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result request changed while stalled");

  a_status_code: assert property (@(posedge clk_i)
    m_axis_tvalid |-> (m_axis_tuser == ST_FOUND || m_axis_tuser == ST_NOT_FOUND ||
                       m_axis_tuser == ST_CANCELLED))
    else $error("undefined status code");

  a_offset_zero: assert property (@(posedge clk_i)
    m_axis_tvalid && m_axis_tuser != ST_FOUND |-> m_axis_tdata == '0)
    else $error("non-found result carries an offset");

  a_stall_cause: assert property (@(posedge clk_i)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

endmodule

bind byte_stream_substring_finder bsf_checker u_bsf_checker (.*);
